// ----- rtl/core/projective_point_transform_defines.svh -----
// Assertion macros for the checker of the projective point transform
`ifndef PROJECTIVE_POINT_TRANSFORM_DEFINES_SVH
`define PROJECTIVE_POINT_TRANSFORM_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define PPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppt assertion failed");

// Next-cycle implication, off while reset is held
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppt assertion failed");

// Implication that also holds through reset
`define PPT_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("ppt assertion failed");

`endif

// ----- rtl/core/ppt_pkg.sv -----
// Types and constants of the projective point transform
`timescale 1ns / 1ps

package ppt_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = 64;
    localparam int FRAC_BITS = 16;
    localparam int DOT_W     = 50;
    localparam int DIV_STEPS = 33;
    localparam int ONE_Q16   = 65536;

    typedef enum logic [1:0] {
        PATH_ZERO = 2'd0,
        PATH_ONE  = 2'd1,
        PATH_DIV  = 2'd2
    } t_path;

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] t_matrix;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         path_taken;
        logic               saturated;
    } t_out_word;

    // Word info that rides beside the dividers
    typedef struct packed {
        t_path            path;
        logic [2:0][31:0] one_val;
        logic             one_sat;
    } t_side;

endpackage

// ----- rtl/core/ppt_dot.sv -----
// Dot products of the four matrix rows with (x, y, z, 1): three register stages
`timescale 1ns / 1ps

module ppt_dot #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  ppt_pkg::t_in_word                     i_word,
    input  ppt_pkg::t_matrix                      i_matrix,
    output logic                                  o_valid,
    output logic [3:0][ppt_pkg::DOT_W-1:0]        o_dot
);

    logic signed [COORD_WIDTH-1:0]     w_lo [3];
    logic signed [31:0]                r_p [3];
    logic signed [ppt_pkg::PROD_W-1:0] r_prod [4][3];
    logic signed [31:0]                r_c3 [4];
    logic signed [ppt_pkg::DOT_W-1:0]  r_dot [4];
    logic                              r_v1, r_v2, r_v3;

    // Take the low coordinate bits and sign-extend them
    assign w_lo[0] = i_word.point_x[COORD_WIDTH-1:0];
    assign w_lo[1] = i_word.point_y[COORD_WIDTH-1:0];
    assign w_lo[2] = i_word.point_z[COORD_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= 32'(w_lo[k]);
            end
        end
    end

    // Form the exact products, one multiplier per coefficient
    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            logic signed [31:0] w_coef;
            assign w_coef = signed'(i_matrix[r*2 + c/2][(c%2)*32 +: 32]);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_prod[r][c] <= w_coef * r_p[c];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c3[r] <= signed'(i_matrix[r*2 + 1][63:32]);
            end
        end

        // Floor each product to Q16.16 and sum with the column 3 term
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dot[r] <= ppt_pkg::DOT_W'(r_c3[r])
                          + ppt_pkg::DOT_W'(r_prod[r][0] >>> ppt_pkg::FRAC_BITS)
                          + ppt_pkg::DOT_W'(r_prod[r][1] >>> ppt_pkg::FRAC_BITS)
                          + ppt_pkg::DOT_W'(r_prod[r][2] >>> ppt_pkg::FRAC_BITS);
            end
        end
        assign o_dot[r] = r_dot[r];
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;

endmodule

// ----- rtl/core/ppt_div.sv -----
// Restoring divider of magnitudes, one quotient bit per register stage
`timescale 1ns / 1ps

module ppt_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [ppt_pkg::DOT_W-1:0]         i_md,
    input  logic [ppt_pkg::DOT_W-1:0]         i_ms,
    input  logic                              i_neg,
    output logic [ppt_pkg::DIV_STEPS-1:0]     o_q,
    output logic                              o_ovf,
    output logic                              o_neg
);

    localparam int QW = ppt_pkg::DIV_STEPS;
    localparam int DW = ppt_pkg::DOT_W;
    localparam int SH = QW - ppt_pkg::FRAC_BITS;

    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_md  [QW];
    logic [DW-1:0] r_ms  [QW];
    logic [QW-1:0] r_q   [QW];
    logic          r_neg [QW];
    logic          r_ovf [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] w_rin, w_md, w_ms;
        logic [QW-1:0] w_qin;
        logic          w_neg, w_ovf, w_dbit, w_ge;
        logic [DW:0]   w_trial;

        // Quotient of 2^QW or more saturates; flag it on the way in
        if (k == 0) begin : g_first
            assign w_rin = i_md >> SH;
            assign w_md  = i_md;
            assign w_ms  = i_ms;
            assign w_qin = '0;
            assign w_neg = i_neg;
            assign w_ovf = {{SH{1'b0}}, i_md} >= {i_ms, {SH{1'b0}}};
        end else begin : g_next
            assign w_rin = r_rem[k-1];
            assign w_md  = r_md[k-1];
            assign w_ms  = r_ms[k-1];
            assign w_qin = r_q[k-1];
            assign w_neg = r_neg[k-1];
            assign w_ovf = r_ovf[k-1];
        end

        // Bring down the next dividend bit of md * 2^16
        if (QW - 1 - k >= ppt_pkg::FRAC_BITS) begin : g_mdbit
            assign w_dbit = w_md[QW - 1 - k - ppt_pkg::FRAC_BITS];
        end else begin : g_zbit
            assign w_dbit = 1'b0;
        end

        assign w_trial = {w_rin, w_dbit};
        assign w_ge    = w_trial >= {1'b0, w_ms};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? DW'(w_trial - {1'b0, w_ms}) : DW'(w_trial);
                r_q[k]   <= w_qin | (QW'(w_ge) << (QW - 1 - k));
                r_md[k]  <= w_md;
                r_ms[k]  <= w_ms;
                r_neg[k] <= w_neg;
                r_ovf[k] <= w_ovf;
            end
        end
    end

    assign o_q   = r_q[QW-1];
    assign o_ovf = r_ovf[QW-1];
    assign o_neg = r_neg[QW-1];

endmodule

// ----- rtl/core/projective_point_transform.sv -----
// Top level of the projective point transform: config, prep, dividers, output
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+----------------------------
//  in      | receive   | i_in_valid/o_in_stall | point_x, point_y, point_z
//  out     | send      | o_out_valid/i_out_stall | out_x..z, path, saturated
//  cfg     | receive   | i_cfg_wr_en          | i_cfg_index, i_cfg_data
//
// One word per cycle while the output is not stalled; stages: input, multiply, sum, prep, 33 divider
// steps (one quotient bit each) and the output register.
// Reset clears the valid bits and the matrix registers.
// A stalled output word freezes the whole pipeline; the input stalls with it.
`timescale 1ns / 1ps

module projective_point_transform #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ppt_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ppt_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_wr_en,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ppt_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int DW = ppt_pkg::DOT_W;
    localparam int QW = ppt_pkg::DIV_STEPS;
    localparam logic signed [DW-1:0] POS_LIM = (DW'(1) <<< (COORD_WIDTH - 1)) - DW'(1);
    localparam logic signed [DW-1:0] NEG_LIM = -(DW'(1) <<< (COORD_WIDTH - 1));
    localparam logic [QW-1:0] POS_QMAX = QW'(POS_LIM);
    localparam logic [QW-1:0] NEG_QMAX = QW'(-NEG_LIM);
    localparam logic [31:0]   POS_OUT  = 32'(POS_LIM);
    localparam logic [31:0]   NEG_OUT  = 32'(NEG_LIM);

    ppt_pkg::t_matrix          r_matrix;
    logic                      w_en;
    logic                      w_dot_valid;
    logic [3:0][DW-1:0]        w_dot;
    logic signed [DW-1:0]      w_s;
    logic [DW-1:0]             w_ms;
    ppt_pkg::t_side            n_side;
    logic [DW-1:0]             n_md [3];
    logic                      n_neg [3];
    ppt_pkg::t_side            r_side;
    logic [DW-1:0]             r_md [3];
    logic [DW-1:0]             r_ms;
    logic                      r_neg [3];
    logic                      r_pv;
    ppt_pkg::t_side            r_side_dl [QW];
    logic                      r_vld_dl [QW];
    logic [QW-1:0]             w_q [3];
    logic                      w_ovf [3];
    logic                      w_qneg [3];
    ppt_pkg::t_out_word        n_out;
    ppt_pkg::t_out_word        r_out;
    logic                      r_out_valid;

    // Write the matrix registers; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix <= '0;
        end else if (i_cfg_wr_en && i_cfg_index < ppt_pkg::CFG_IDX_W'(ppt_pkg::NUM_REGS)) begin
            r_matrix[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // Hold every stage while a finished word waits
    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    ppt_dot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_word   (i_in_word),
        .i_matrix (r_matrix),
        .o_valid  (w_dot_valid),
        .o_dot    (w_dot)
    );

    // Classify the scale, take magnitudes and clamp the unit-scale results
    assign w_s  = signed'(w_dot[3]);
    assign w_ms = w_s[DW-1] ? DW'(-w_s) : DW'(w_s);

    always_comb begin
        logic signed [DW-1:0] d;
        if (w_s == DW'(0)) begin
            n_side.path = ppt_pkg::PATH_ZERO;
        end else if (w_s == DW'(ppt_pkg::ONE_Q16)) begin
            n_side.path = ppt_pkg::PATH_ONE;
        end else begin
            n_side.path = ppt_pkg::PATH_DIV;
        end
        n_side.one_sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            d        = signed'(w_dot[k]);
            n_md[k]  = d[DW-1] ? DW'(-d) : DW'(d);
            n_neg[k] = d[DW-1] ^ w_s[DW-1];
            if (d > POS_LIM) begin
                n_side.one_val[k] = POS_OUT;
                n_side.one_sat    = 1'b1;
            end else if (d < NEG_LIM) begin
                n_side.one_val[k] = NEG_OUT;
                n_side.one_sat    = 1'b1;
            end else begin
                n_side.one_val[k] = 32'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side <= n_side;
            r_ms   <= w_ms;
            for (int k = 0; k < 3; k++) begin
                r_md[k]  <= n_md[k];
                r_neg[k] <= n_neg[k];
            end
        end
    end

    // Divide each coordinate by the scale
    for (genvar k = 0; k < 3; k++) begin : g_lane
        ppt_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_md  (r_md[k]),
            .i_ms  (r_ms),
            .i_neg (r_neg[k]),
            .o_q   (w_q[k]),
            .o_ovf (w_ovf[k]),
            .o_neg (w_qneg[k])
        );
    end

    // Carry the side info beside the dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side_dl[0] <= r_side;
            for (int k = 1; k < QW; k++) begin
                r_side_dl[k] <= r_side_dl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            for (int k = 0; k < QW; k++) begin
                r_vld_dl[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_pv        <= w_dot_valid;
            r_vld_dl[0] <= r_pv;
            for (int k = 1; k < QW; k++) begin
                r_vld_dl[k] <= r_vld_dl[k-1];
            end
        end
    end

    // Pick the result by path and saturate the quotients
    always_comb begin
        logic [31:0] v [3];
        logic        sat;
        sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            v[k] = '0;
        end
        case (r_side_dl[QW-1].path)
            ppt_pkg::PATH_ONE: begin
                for (int k = 0; k < 3; k++) begin
                    v[k] = r_side_dl[QW-1].one_val[k];
                end
                sat = r_side_dl[QW-1].one_sat;
            end
            ppt_pkg::PATH_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    if (w_ovf[k] || (w_qneg[k] ? (w_q[k] > NEG_QMAX) : (w_q[k] > POS_QMAX))) begin
                        v[k] = w_qneg[k] ? NEG_OUT : POS_OUT;
                        sat  = 1'b1;
                    end else begin
                        v[k] = w_qneg[k] ? 32'(-{1'b0, w_q[k]}) : 32'(w_q[k]);
                    end
                end
            end
            default: begin
                sat = 1'b0;
            end
        endcase
        n_out.out_x      = v[0];
        n_out.out_y      = v[1];
        n_out.out_z      = v[2];
        n_out.path_taken = r_side_dl[QW-1].path;
        n_out.saturated  = sat;
    end

    // Register the output word
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vld_dl[QW-1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ----- rtl/core/ppt_chk.sv -----
// Port checker of the projective point transform, bound to the top level
`timescale 1ns / 1ps
`include "projective_point_transform_defines.svh"

module ppt_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ppt_pkg::t_out_word o_out_word
);

    // A stalled output word stays in place
    `PPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_word))

    // The input stalls only behind a stalled output word
    `PPT_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // A zero scale gives the zero point without saturation
    `PPT_ASSERT_IMPL(a_zero_path, i_clk, i_rst_n,
        o_out_valid && o_out_word.path_taken == ppt_pkg::PATH_ZERO,
        o_out_word.out_x == 32'sd0 && o_out_word.out_y == 32'sd0
            && o_out_word.out_z == 32'sd0 && !o_out_word.saturated)

    // Nothing leaves the cycle after reset
    `PPT_ASSERT_ALWAYS(a_reset_idle, i_clk, $past(!i_rst_n), !o_out_valid)

endmodule

bind projective_point_transform ppt_chk u_ppt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
